@@ hdl/signed_decimal_seven_segment_format_macros.svh @@
// assertion macros used by the controller module
// no dependencies; included inside module bodies
`ifndef SIGNED_DECIMAL_SEVEN_SEGMENT_FORMAT_MACROS_SVH
`define SIGNED_DECIMAL_SEVEN_SEGMENT_FORMAT_MACROS_SVH

// same-cycle implication, disabled during reset
`define SDSSF_ASSERT_NOW(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("sdssf assertion failed");

// next-cycle implication, disabled during reset
`define SDSSF_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("sdssf assertion failed");

`endif

@@ hdl/sdssf_pkg.sv @@
// types, constants and segment encoding for the signed decimal formatter
// no dependencies
package sdssf_pkg;

   localparam int unsigned IN_WIDTH   = 31;
   localparam int unsigned MAG_WIDTH  = 31;
   localparam int unsigned BCD_DIGITS = 10;
   localparam int unsigned BCD_WIDTH  = 4 * BCD_DIGITS;
   localparam int unsigned ITERATIONS = MAG_WIDTH;
   localparam int unsigned CNT_WIDTH  = 5;
   localparam int unsigned SEG_WIDTH  = 8;
   localparam int unsigned POS_MAX    = 8;

   localparam logic [SEG_WIDTH-1:0] SEG_MINUS = 8'h01;
   localparam logic [SEG_WIDTH-1:0] SEG_POINT = 8'h80;
   localparam logic [IN_WIDTH:0]    ROUND_OFFSET = 32'd5;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_CONVERT,
      ST_DONE
   } state_type;

   typedef struct packed {
      logic load;
      logic shift;
      logic capture;
   } ctl_cmd_type;

   function automatic logic [SEG_WIDTH-1:0] digit_segments(input logic [3:0] digit);
      logic [SEG_WIDTH-1:0] seg;
      case (digit)
         4'd0: seg = 8'h7E;
         4'd1: seg = 8'h30;
         4'd2: seg = 8'h6D;
         4'd3: seg = 8'h79;
         4'd4: seg = 8'h33;
         4'd5: seg = 8'h5B;
         4'd6: seg = 8'h5F;
         4'd7: seg = 8'h70;
         4'd8: seg = 8'h7F;
         4'd9: seg = 8'h7B;
         default: seg = 8'h00;
      endcase
      return seg;
   endfunction

endpackage

@@ hdl/sdssf_ctrl.sv @@
// controller: request/result handshake, conversion step counter, output register flag
// depends on sdssf_pkg and signed_decimal_seven_segment_format_macros.svh
module sdssf_ctrl (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_ready,
   output logic                 rsp_valid,
   input  logic                 rsp_ready,
   output sdssf_pkg::ctl_cmd_type cmd
);
   import sdssf_pkg::*;

   `include "signed_decimal_seven_segment_format_macros.svh"

   localparam logic [CNT_WIDTH-1:0] LAST_STEP = CNT_WIDTH'(ITERATIONS - 1);

   state_type            state_ff, state_in;
   logic [CNT_WIDTH-1:0] count_ff, count_in;
   logic                 full_ff, full_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         count_ff <= '0;
         full_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         count_ff <= count_in;
         full_ff  <= full_in;
      end
   end

   always_comb begin
      state_in    = state_ff;
      count_in    = count_ff;
      full_in     = full_ff && !rsp_ready;
      req_ready   = 1'b0;
      cmd.load    = 1'b0;
      cmd.shift   = 1'b0;
      cmd.capture = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.load = 1'b1;
               count_in = '0;
               state_in = ST_CONVERT;
            end
         end
         ST_CONVERT: begin
            cmd.shift = 1'b1;
            count_in  = count_ff + 1'b1;
            if (count_ff == LAST_STEP) begin
               state_in = ST_DONE;
            end
         end
         ST_DONE: begin
            if (!full_ff || rsp_ready) begin
               cmd.capture = 1'b1;
               full_in     = 1'b1;
               state_in    = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   assign rsp_valid = full_ff;

   `SDSSF_ASSERT_NEXT(a_load_starts, clock, reset, req_valid && req_ready,
      state_ff == ST_CONVERT && count_ff == '0)
   `SDSSF_ASSERT_NOW(a_count_bound, clock, reset, state_ff == ST_CONVERT,
      count_ff <= LAST_STEP)
   `SDSSF_ASSERT_NEXT(a_capture_fills, clock, reset, cmd.capture, rsp_valid)
   `SDSSF_ASSERT_NOW(a_no_overwrite, clock, reset, cmd.capture && rsp_valid, rsp_ready)

endmodule

@@ hdl/sdssf_datapath.sv @@
// datapath: rounding and magnitude, shift-and-add-3 decimal conversion, segment encode
// depends on sdssf_pkg
module sdssf_datapath #(
   parameter int unsigned DISPLAY_POSITIONS = 8
) (
   input  logic                              clock,
   input  sdssf_pkg::ctl_cmd_type            cmd,
   input  logic [sdssf_pkg::IN_WIDTH-1:0]    weight_hundredths,
   output logic [sdssf_pkg::SEG_WIDTH-1:0]   seg_pos [sdssf_pkg::POS_MAX],
   output logic                              overflow
);
   import sdssf_pkg::*;

   logic [MAG_WIDTH-1:0] mag_ff, mag_in;
   logic [BCD_WIDTH-1:0] bcd_ff, bcd_in;
   logic                 neg_ff, neg_in;
   logic [SEG_WIDTH-1:0] seg_ff [POS_MAX];
   logic [SEG_WIDTH-1:0] seg_in [POS_MAX];
   logic                 ovf_ff, ovf_in;

   logic [IN_WIDTH:0]    sum;
   logic [IN_WIDTH:0]    abs_sum;
   logic [BCD_WIDTH-1:0] bcd_adj;
   logic [3:0]           digit [POS_MAX];
   logic                 shown [POS_MAX];

   always_ff @(posedge clock) begin
      mag_ff  <= mag_in;
      bcd_ff  <= bcd_in;
      neg_ff  <= neg_in;
      seg_ff  <= seg_in;
      ovf_ff  <= ovf_in;
   end

   // round, sign and magnitude
   always_comb begin
      sum     = {weight_hundredths[IN_WIDTH-1], weight_hundredths} + ROUND_OFFSET;
      abs_sum = sum[IN_WIDTH] ? (~sum + 1'b1) : sum;
   end

   always_comb begin
      for (int i = 0; i < BCD_DIGITS; i++) begin
         bcd_adj[4*i +: 4] = (bcd_ff[4*i +: 4] >= 4'd5) ? bcd_ff[4*i +: 4] + 4'd3
                                                       : bcd_ff[4*i +: 4];
      end
   end

   always_comb begin
      mag_in = mag_ff;
      bcd_in = bcd_ff;
      neg_in = neg_ff;
      if (cmd.load) begin
         mag_in = abs_sum[MAG_WIDTH-1:0];
         bcd_in = '0;
         neg_in = sum[IN_WIDTH];
      end else if (cmd.shift) begin
         bcd_in = {bcd_adj[BCD_WIDTH-2:0], mag_ff[MAG_WIDTH-1]};
         mag_in = {mag_ff[MAG_WIDTH-2:0], 1'b0};
      end
   end

   // tenths digit i is decimal digit i+1 of the magnitude
   always_comb begin
      ovf_in = 1'b0;
      for (int i = 0; i < BCD_DIGITS; i++) begin
         if (i >= DISPLAY_POSITIONS && bcd_ff[4*i +: 4] != 4'd0) begin
            ovf_in = 1'b1;
         end
      end
      for (int j = 0; j < POS_MAX; j++) begin
         if (j <= DISPLAY_POSITIONS - 2) begin
            digit[j] = ovf_in ? 4'd9 : bcd_ff[4*(j+1) +: 4];
         end else begin
            digit[j] = 4'd0;
         end
      end
      shown[POS_MAX-1] = (digit[POS_MAX-1] != 4'd0);
      for (int j = POS_MAX - 2; j >= 0; j--) begin
         shown[j] = (digit[j] != 4'd0) || shown[j+1] || (j <= 1);
      end
      for (int j = 0; j < POS_MAX; j++) begin
         if (j >= DISPLAY_POSITIONS) begin
            seg_in[j] = '0;
         end else if (shown[j]) begin
            seg_in[j] = digit_segments(digit[j]);
         end else if (neg_ff && j >= 2 && shown[j-1]) begin
            seg_in[j] = SEG_MINUS;
         end else begin
            seg_in[j] = '0;
         end
      end
      seg_in[1] = seg_in[1] | SEG_POINT;
      if (!cmd.capture) begin
         seg_in = seg_ff;
         ovf_in = ovf_ff;
      end
   end

   assign seg_pos  = seg_ff;
   assign overflow = ovf_ff;

endmodule

@@ hdl/signed_decimal_seven_segment_format.sv @@
// signed decimal seven-segment formatter, top level
// an accepted request runs through ST_CONVERT, then ST_DONE captures the result
// one request at a time: the next waits for the 31-step shift-and-add-3 conversion
// a new request is taken while the previous result waits in the output register
// reset (synchronous, active high) clears the controller and the result-valid flag only
// depends on sdssf_pkg, sdssf_ctrl, sdssf_datapath
module signed_decimal_seven_segment_format #(
   parameter int unsigned DISPLAY_POSITIONS = 8
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_valid,
   output logic                                 req_ready,
   input  logic signed [sdssf_pkg::IN_WIDTH-1:0] req_weight_hundredths,
   output logic                                 rsp_valid,
   input  logic                                 rsp_ready,
   output logic [sdssf_pkg::SEG_WIDTH-1:0]      rsp_seg_pos0,
   output logic [sdssf_pkg::SEG_WIDTH-1:0]      rsp_seg_pos1,
   output logic [sdssf_pkg::SEG_WIDTH-1:0]      rsp_seg_pos2,
   output logic [sdssf_pkg::SEG_WIDTH-1:0]      rsp_seg_pos3,
   output logic [sdssf_pkg::SEG_WIDTH-1:0]      rsp_seg_pos4,
   output logic [sdssf_pkg::SEG_WIDTH-1:0]      rsp_seg_pos5,
   output logic [sdssf_pkg::SEG_WIDTH-1:0]      rsp_seg_pos6,
   output logic [sdssf_pkg::SEG_WIDTH-1:0]      rsp_seg_pos7,
   output logic                                 rsp_overflow
);
   import sdssf_pkg::*;

   ctl_cmd_type          cmd;
   logic [SEG_WIDTH-1:0] seg_pos [POS_MAX];

   sdssf_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .cmd       (cmd)
   );

   sdssf_datapath #(
      .DISPLAY_POSITIONS (DISPLAY_POSITIONS)
   ) u_datapath (
      .clock             (clock),
      .cmd               (cmd),
      .weight_hundredths (req_weight_hundredths),
      .seg_pos           (seg_pos),
      .overflow          (rsp_overflow)
   );

   assign rsp_seg_pos0 = seg_pos[0];
   assign rsp_seg_pos1 = seg_pos[1];
   assign rsp_seg_pos2 = seg_pos[2];
   assign rsp_seg_pos3 = seg_pos[3];
   assign rsp_seg_pos4 = seg_pos[4];
   assign rsp_seg_pos5 = seg_pos[5];
   assign rsp_seg_pos6 = seg_pos[6];
   assign rsp_seg_pos7 = seg_pos[7];

endmodule

@@ sim/testbench.sv @@
// self-checking testbench for signed_decimal_seven_segment_format
// a directed table, then random requests, checked against table rows or a display predictor
// depends on sdssf_pkg and the formatter rtl
`timescale 1ns / 1ps

module testbench;
   import sdssf_pkg::*;

   localparam int unsigned POSITIONS    = 8;
   localparam int          RANDOM_ITEMS = 1630;
   localparam int          LIMIT_CYCLES = 800000;
   localparam int          TAIL_CYCLES  = 40;
   localparam int          HOLD_CYCLES  = 600;
   localparam int          HOLD_AFTER   = 300;

   localparam logic [SEG_WIDTH-1:0] GLYPH [10] = '{
      8'h7E, 8'h30, 8'h6D, 8'h79, 8'h33, 8'h5B, 8'h5F, 8'h70, 8'h7F, 8'h7B
   };

   typedef struct packed {
      logic [POS_MAX-1:0][SEG_WIDTH-1:0] seg;
      logic                              overflow;
   } display_type;

   typedef struct {
      logic signed [IN_WIDTH-1:0] weight;
      bit                         known;
      display_type                shows;
   } table_row_type;

   logic                        clock = 1'b0;
   logic                        reset = 1'b1;
   logic                        req_valid = 1'b0;
   logic                        req_ready;
   logic signed [IN_WIDTH-1:0]  req_weight_hundredths = '0;
   logic                        rsp_valid;
   logic                        rsp_ready = 1'b0;
   logic [SEG_WIDTH-1:0]        rsp_seg_pos0, rsp_seg_pos1, rsp_seg_pos2, rsp_seg_pos3;
   logic [SEG_WIDTH-1:0]        rsp_seg_pos4, rsp_seg_pos5, rsp_seg_pos6, rsp_seg_pos7;
   logic                        rsp_overflow;

   display_type   pending_displays [$];
   table_row_type stimulus_table [$];
   int            requests_in = 0;
   int            mismatches = 0;
   int            burst_left = 0;
   int            cycle_count;
   bit            hold_done = 0;

   signed_decimal_seven_segment_format #(
      .DISPLAY_POSITIONS(POSITIONS)
   ) dut (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_ready(req_ready),
      .req_weight_hundredths(req_weight_hundredths),
      .rsp_valid(rsp_valid),
      .rsp_ready(rsp_ready),
      .rsp_seg_pos0(rsp_seg_pos0),
      .rsp_seg_pos1(rsp_seg_pos1),
      .rsp_seg_pos2(rsp_seg_pos2),
      .rsp_seg_pos3(rsp_seg_pos3),
      .rsp_seg_pos4(rsp_seg_pos4),
      .rsp_seg_pos5(rsp_seg_pos5),
      .rsp_seg_pos6(rsp_seg_pos6),
      .rsp_seg_pos7(rsp_seg_pos7),
      .rsp_overflow(rsp_overflow)
   );

   initial begin
      forever #6 clock = ~clock;
   end

   function automatic display_type format_display(input logic signed [IN_WIDTH-1:0] weight);
      display_type     d;
      longint          total;
      longint unsigned mag;
      longint unsigned tenths;
      longint unsigned int_part;
      longint unsigned limit;
      bit              negative;
      int              k;
      d = '0;
      limit = 1;
      for (k = 0; k < POSITIONS - 1; k++) limit = limit * 10;
      limit = limit - 1;
      total = longint'(weight) + 5;
      negative = total < 0;
      mag = negative ? longint'(-total) : longint'(total);
      tenths = mag / 10;
      if (tenths > limit) begin
         tenths = limit;
         d.overflow = 1'b1;
      end
      d.seg[0] = GLYPH[tenths % 10];
      int_part = tenths / 10;
      k = 1;
      do begin
         d.seg[k] = GLYPH[int_part % 10];
         int_part = int_part / 10;
         k++;
      end while (int_part != 0 && k < POSITIONS);
      if (negative && k < POSITIONS) d.seg[k] = SEG_MINUS;
      d.seg[1] = d.seg[1] | SEG_POINT;
      return d;
   endfunction

   function automatic display_type shown(input logic [SEG_WIDTH-1:0] p7, p6, p5, p4, p3, p2,
                                         input logic [SEG_WIDTH-1:0] p1, p0,
                                         input logic ovf);
      display_type d;
      d.seg = {p7, p6, p5, p4, p3, p2, p1, p0};
      d.overflow = ovf;
      return d;
   endfunction

   function automatic logic signed [IN_WIDTH-1:0] random_weight();
      longint          w;
      longint unsigned span;
      int              n;
      int              pick;
      pick = $urandom_range(0, 99);
      if (pick < 30) begin
         w = longint'($urandom_range(0, 2000000000)) - 64'sd1000000000;
      end else if (pick < 55) begin
         n = $urandom_range(1, 9);
         span = 1;
         repeat (n) span = span * 10;
         w = longint'($urandom_range(0, int'(span - 1)));
         if ($urandom_range(0, 1)) w = -w;
      end else if (pick < 75) begin
         w = longint'($urandom_range(0, 4000)) - 2000;
      end else if (pick < 90) begin
         w = longint'($urandom_range(0, 40)) - 20;
         w = $urandom_range(0, 1) ? w + 99999995 : w - 100000005;
      end else begin
         w = 1000000000 - longint'($urandom_range(0, 100));
         if ($urandom_range(0, 1)) w = -w;
      end
      return w[IN_WIDTH-1:0];
   endfunction

   task automatic add_row(input logic signed [IN_WIDTH-1:0] weight, input bit known,
                          input display_type shows);
      table_row_type r;
      r.weight = weight;
      r.known = known;
      r.shows = shows;
      stimulus_table.push_back(r);
   endtask

   // called in the time step of a rising edge; returns in the time step of the accepting edge
   task automatic send_request(input logic signed [IN_WIDTH-1:0] weight,
                               input display_type shows);
      int gap;
      if (burst_left == 0) begin
         gap = $urandom_range(0, 40);
         if (gap > 0) begin
            req_valid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         burst_left = $urandom_range(1, 30);
      end
      burst_left--;
      req_valid <= 1'b1;
      req_weight_hundredths <= weight;
      forever begin
         @(negedge clock);
         if (req_ready) break;
         @(posedge clock);
      end
      pending_displays.push_back(shows);
      requests_in++;
      @(posedge clock);
   endtask

   // receiver stall pattern, with one long hold-off once traffic is flowing
   initial begin : receiver
      int mode;
      int len;
      @(posedge clock);
      while (reset) @(posedge clock);
      forever begin
         if (!hold_done && requests_in >= HOLD_AFTER) begin
            hold_done = 1;
            rsp_ready <= 1'b0;
            repeat (HOLD_CYCLES) @(posedge clock);
         end else begin
            mode = $urandom_range(0, 3);
            len = $urandom_range(1, 40);
            repeat (len) begin
               case (mode)
                  0: rsp_ready <= 1'b1;
                  1: rsp_ready <= ($urandom_range(0, 3) != 0);
                  2: rsp_ready <= ($urandom_range(0, 3) == 0);
                  default: rsp_ready <= 1'b0;
               endcase
               @(posedge clock);
            end
         end
      end
   end

   // compare each accepted result against the oldest pending display
   always @(negedge clock) begin : check_rsp
      display_type want;
      display_type got;
      int          p;
      if (!reset && rsp_valid && rsp_ready) begin
         got.seg = {rsp_seg_pos7, rsp_seg_pos6, rsp_seg_pos5, rsp_seg_pos4,
                    rsp_seg_pos3, rsp_seg_pos2, rsp_seg_pos1, rsp_seg_pos0};
         got.overflow = rsp_overflow;
         if (pending_displays.size() == 0) begin
            $error("unexpected result with no request pending");
            mismatches++;
         end else begin
            want = pending_displays.pop_front();
            for (p = 0; p < POS_MAX; p++) begin
               if (got.seg[p] !== want.seg[p]) begin
                  $error("seg_pos%0d expected %02h actual %02h", p, want.seg[p], got.seg[p]);
                  mismatches++;
               end
            end
            if (got.overflow !== want.overflow) begin
               $error("overflow expected %0b actual %0b", want.overflow, got.overflow);
               mismatches++;
            end
         end
      end
   end

   initial begin : watchdog
      for (cycle_count = 0; cycle_count < LIMIT_CYCLES; cycle_count++) @(posedge clock);
      $display("CHECKS FAILED");
      $finish;
   end

   initial begin : stimulus
      logic [SEG_WIDTH-1:0]       n9;
      logic [SEG_WIDTH-1:0]       n0;
      logic signed [IN_WIDTH-1:0] w;
      display_type                d;
      int                         i;
      n9 = GLYPH[9];
      n0 = GLYPH[0];
      d = '0;

      add_row(0, 1, shown(0, 0, 0, 0, 0, 0, n0 | SEG_POINT, n0, 1'b0));
      add_row(1000000000, 1, shown(0, n9, n9, n9, n9, n9, n9 | SEG_POINT, n9, 1'b1));
      add_row(-1000000000, 1,
              shown(SEG_MINUS, n9, n9, n9, n9, n9, n9 | SEG_POINT, n9, 1'b1));
      add_row(99999995, 1, shown(0, n9, n9, n9, n9, n9, n9 | SEG_POINT, n9, 1'b1));
      add_row(-100000005, 1,
              shown(SEG_MINUS, n9, n9, n9, n9, n9, n9 | SEG_POINT, n9, 1'b1));
      // negative sum below one tenth keeps the minus
      add_row(-6, 1, shown(0, 0, 0, 0, 0, SEG_MINUS, n0 | SEG_POINT, n0, 1'b0));
      add_row(-14, 1, shown(0, 0, 0, 0, 0, SEG_MINUS, n0 | SEG_POINT, n0, 1'b0));
      add_row(-5, 1, shown(0, 0, 0, 0, 0, 0, n0 | SEG_POINT, n0, 1'b0));
      add_row(4, 1, shown(0, 0, 0, 0, 0, 0, n0 | SEG_POINT, n0, 1'b0));
      add_row(5, 0, d);
      add_row(-15, 0, d);
      add_row(-1, 0, d);
      add_row(99999994, 0, d);
      add_row(-100000004, 0, d);
      add_row(12345678, 0, d);
      add_row(-12345678, 0, d);
      add_row(98765432, 0, d);
      add_row(-98765, 0, d);
      add_row(95, 0, d);
      add_row(-995, 0, d);
      add_row(9995, 0, d);
      add_row(100, 0, d);
      add_row(-999999, 0, d);

      repeat (2) @(posedge clock);
      reset <= 1'b0;

      foreach (stimulus_table[i]) begin
         w = stimulus_table[i].weight;
         send_request(w, stimulus_table[i].known ? stimulus_table[i].shows : format_display(w));
      end
      for (i = 0; i < RANDOM_ITEMS; i++) begin
         w = random_weight();
         send_request(w, format_display(w));
      end
      req_valid <= 1'b0;

      while (pending_displays.size() != 0) @(posedge clock);
      repeat (TAIL_CYCLES) @(posedge clock);
      if (pending_displays.size() != 0) begin
         $error("%0d results never arrived", pending_displays.size());
         mismatches++;
      end
      if (mismatches == 0) begin
         $display("ALL CHECKS PASSED");
      end else begin
         $display("CHECKS FAILED");
      end
      $finish;
   end

endmodule
